// ===== rtl/emp_pkg.sv =====
// shared types, constants and binary32 helper functions for the elastic material block
`default_nettype none

package emp_pkg;

   // operation performed by one floating-point unit
   typedef enum logic [1:0] {
      OP_ADD,
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } emp_op_type;

   // binary32 constants
   localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
   localparam logic [31:0] FP_TWO    = 32'h4000_0000;
   localparam logic [31:0] FP_THREE  = 32'h4040_0000;
   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

   // unit latencies in cycles
   localparam int LAT_AM     = 2;
   localparam int DIV_STEPS  = 27;
   localparam int LAT_DIV    = DIV_STEPS + 2;
   localparam int SQRT_STEPS = 25;
   localparam int LAT_SQRT   = SQRT_STEPS + 2;

   // special-case classification of a result
   typedef struct packed {
      logic nan;
      logic inf;
      logic zero;
      logic sgn;
   } emp_flags_type;

   // one stage of the restoring divider
   typedef struct packed {
      emp_flags_type      flags;
      logic signed [11:0] ex;
      logic [23:0]        den;
      logic [24:0]        rem;
      logic [26:0]        quo;
   } emp_div_type;

   // one stage of the digit-by-digit square root
   typedef struct packed {
      emp_flags_type      flags;
      logic signed [11:0] ex;
      logic [49:0]        rad;
      logic [26:0]        rem;
      logic [24:0]        root;
   } emp_sqrt_type;

   function automatic logic is_nan(input logic [31:0] a);
      return (&a[30:23]) && (|a[22:0]);
   endfunction

   function automatic logic is_inf(input logic [31:0] a);
      return (&a[30:23]) && !(|a[22:0]);
   endfunction

   function automatic logic is_zero(input logic [31:0] a);
      return a[30:0] == 31'd0;
   endfunction

   // significand with hidden bit, subnormals left unnormalized
   function automatic logic [23:0] mant_of(input logic [31:0] a);
      return {|a[30:23], a[22:0]};
   endfunction

   // biased exponent, subnormals read as one
   function automatic logic [7:0] exp_of(input logic [31:0] a);
      return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
   endfunction

   // leading zero count, 48 when all bits are clear
   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       found;
      n     = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 6'(47 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // round to nearest even and pack; m[25] hidden, m[1] round, m[0] sticky
   function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] ex,
                                              input logic [25:0] m);
      logic signed [11:0] shw;
      logic [4:0]         sh;
      logic [31:0]        mw;
      logic [31:0]        ms;
      logic [31:0]        mk;
      logic [25:0]        mr;
      logic [7:0]         ef;
      logic               inc;
      logic [24:0]        m24;
      logic [30:0]        mag;
      logic [31:0]        res;
      shw = 12'sd1 - ex;
      sh  = (shw > 12'sd31) ? 5'd31 : shw[4:0];
      mw  = {6'd0, m};
      ms  = mw >> sh;
      mk  = mw & ((32'd1 << sh) - 32'd1);
      if (ex < 12'sd1) begin
         mr = {ms[25:1], ms[0] | (|mk)};
         ef = 8'd0;
      end else begin
         mr = m;
         ef = ex[7:0] - 8'd1;
      end
      inc = mr[1] & (mr[0] | mr[2]);
      m24 = {1'b0, mr[25:2]} + {24'd0, inc};
      mag = {ef, 23'd0} + {6'd0, m24};
      if (ex > 12'sd254) begin
         res = {sgn, 8'hFF, 23'd0};
      end else begin
         res = {sgn, mag};
      end
      return res;
   endfunction

   // special cases take precedence over the packed value
   function automatic logic [31:0] finish(input emp_flags_type f, input logic [31:0] packed_val);
      logic [31:0] res;
      if (f.nan) begin
         res = CANON_NAN;
      end else if (f.inf) begin
         res = {f.sgn, 8'hFF, 23'd0};
      end else if (f.zero) begin
         res = {f.sgn, 31'd0};
      end else begin
         res = packed_val;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/emp_fpu.sv =====
// pipelined binary32 unit: add, multiply, divide or square root
`default_nettype none

module emp_fpu
   import emp_pkg::*;
#(
   parameter emp_op_type OP = OP_ADD
) (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic      [31:0] result
);

   if (OP == OP_ADD) begin : g_add
      logic [27:0]        sum_ff;
      logic [27:0]        sum_in;
      logic signed [11:0] ex_ff;
      logic signed [11:0] ex_in;
      emp_flags_type      flags_ff;
      emp_flags_type      flags_in;
      logic               zsgn_ff;
      logic               zsgn_in;
      logic [31:0]        y_ff;
      logic [31:0]        y_in;

      // order by magnitude, align the smaller operand, add or subtract
      always_comb begin
         logic [31:0] x;
         logic [31:0] y;
         logic [7:0]  d;
         logic [4:0]  sh;
         logic [31:0] yw;
         logic [31:0] ys;
         logic [31:0] yk;
         logic [27:0] xa;
         logic [27:0] ya;
         logic        eff_sub;
         if (op_a[30:0] >= op_b[30:0]) begin
            x = op_a;
            y = op_b;
         end else begin
            x = op_b;
            y = op_a;
         end
         eff_sub = x[31] ^ y[31];
         d       = exp_of(x) - exp_of(y);
         sh      = (d > 8'd27) ? 5'd28 : d[4:0];
         yw      = {5'd0, mant_of(y), 3'd0};
         ys      = yw >> sh;
         yk      = yw & ((32'd1 << sh) - 32'd1);
         xa      = {1'b0, mant_of(x), 3'd0};
         ya      = {ys[27:1], ys[0] | (|yk)};
         sum_in  = eff_sub ? (xa - ya) : (xa + ya);
         ex_in   = {4'd0, exp_of(x)};
         zsgn_in = eff_sub ? 1'b0 : x[31];
         flags_in.nan  = is_nan(op_a) || is_nan(op_b) ||
                         (is_inf(op_a) && is_inf(op_b) && eff_sub);
         flags_in.inf  = is_inf(op_a) || is_inf(op_b);
         flags_in.zero = 1'b0;
         flags_in.sgn  = x[31];
      end

      // normalize and round
      always_comb begin
         logic [5:0]         lz;
         logic [27:0]        sn;
         logic signed [11:0] en_ex;
         emp_flags_type      f;
         lz    = lzc48({sum_ff, 20'd0});
         sn    = sum_ff << lz;
         en_ex = ex_ff + 12'sd1 - $signed({6'd0, lz});
         f     = flags_ff;
         if (sum_ff == 28'd0) begin
            f.zero = 1'b1;
            if (!f.inf) begin
               f.sgn = zsgn_ff;
            end
         end
         y_in = finish(f, round_pack(flags_ff.sgn, en_ex, {sn[27:3], |sn[2:0]}));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sum_ff   <= sum_in;
            ex_ff    <= ex_in;
            flags_ff <= flags_in;
            zsgn_ff  <= zsgn_in;
            y_ff     <= y_in;
         end
      end

      assign result = y_ff;

   end else if (OP == OP_MUL) begin : g_mul
      logic [47:0]        prod_ff;
      logic [47:0]        prod_in;
      logic signed [11:0] ex_ff;
      logic signed [11:0] ex_in;
      emp_flags_type      flags_ff;
      emp_flags_type      flags_in;
      logic [31:0]        y_ff;
      logic [31:0]        y_in;

      // significand product and exponent sum
      always_comb begin
         prod_in = mant_of(op_a) * mant_of(op_b);
         ex_in   = {4'd0, exp_of(op_a)} + {4'd0, exp_of(op_b)} - 12'sd127;
         flags_in.nan  = is_nan(op_a) || is_nan(op_b) ||
                         (is_inf(op_a) && is_zero(op_b)) || (is_zero(op_a) && is_inf(op_b));
         flags_in.inf  = is_inf(op_a) || is_inf(op_b);
         flags_in.zero = is_zero(op_a) || is_zero(op_b);
         flags_in.sgn  = op_a[31] ^ op_b[31];
      end

      // normalize and round
      always_comb begin
         logic [5:0]         lz;
         logic [47:0]        pn;
         logic signed [11:0] en_ex;
         lz    = lzc48(prod_ff);
         pn    = prod_ff << lz;
         en_ex = ex_ff + 12'sd1 - $signed({6'd0, lz});
         y_in  = finish(flags_ff, round_pack(flags_ff.sgn, en_ex, {pn[47:23], |pn[22:0]}));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff  <= prod_in;
            ex_ff    <= ex_in;
            flags_ff <= flags_in;
            y_ff     <= y_in;
         end
      end

      assign result = y_ff;

   end else if (OP == OP_DIV) begin : g_div
      emp_div_type dv_ff [DIV_STEPS+1];
      emp_div_type dv_in;
      logic [31:0] y_ff;
      logic [31:0] y_in;

      // one quotient bit per stage
      function automatic emp_div_type div_step(input emp_div_type s);
         emp_div_type n;
         logic        ge;
         n       = s;
         ge      = s.rem >= {1'b0, s.den};
         n.rem   = (ge ? (s.rem - {1'b0, s.den}) : s.rem) << 1;
         n.quo   = {s.quo[25:0], ge};
         return n;
      endfunction

      // normalize both significands, set up the recurrence
      always_comb begin
         logic [5:0]  lza;
         logic [5:0]  lzb;
         logic [23:0] man;
         logic [23:0] mbn;
         lza = lzc48({mant_of(op_a), 24'd0});
         lzb = lzc48({mant_of(op_b), 24'd0});
         man = mant_of(op_a) << lza;
         mbn = mant_of(op_b) << lzb;
         dv_in.ex  = {4'd0, exp_of(op_a)} - $signed({6'd0, lza})
                     - {4'd0, exp_of(op_b)} + $signed({6'd0, lzb}) + 12'sd126;
         dv_in.den = mbn;
         dv_in.rem = {1'b0, man};
         dv_in.quo = 27'd0;
         dv_in.flags.nan  = is_nan(op_a) || is_nan(op_b) ||
                            (is_zero(op_a) && is_zero(op_b)) || (is_inf(op_a) && is_inf(op_b));
         dv_in.flags.inf  = is_inf(op_a) || is_zero(op_b);
         dv_in.flags.zero = is_zero(op_a) || is_inf(op_b);
         dv_in.flags.sgn  = op_a[31] ^ op_b[31];
      end

      // pick the significand window and round
      always_comb begin
         emp_div_type        s;
         logic               rem_nz;
         logic [25:0]        m;
         logic signed [11:0] ex;
         s      = dv_ff[DIV_STEPS];
         rem_nz = s.rem != 25'd0;
         if (s.quo[26]) begin
            m  = {s.quo[26:2], s.quo[1] | s.quo[0] | rem_nz};
            ex = s.ex + 12'sd1;
         end else begin
            m  = {s.quo[25:1], s.quo[0] | rem_nz};
            ex = s.ex;
         end
         y_in = finish(s.flags, round_pack(s.flags.sgn, ex, m));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[0] <= dv_in;
            for (int k = 0; k < DIV_STEPS; k++) begin
               dv_ff[k+1] <= div_step(dv_ff[k]);
            end
            y_ff <= y_in;
         end
      end

      assign result = y_ff;

   end else begin : g_sqrt
      emp_sqrt_type sq_ff [SQRT_STEPS+1];
      emp_sqrt_type sq_in;
      logic [31:0]  y_ff;
      logic [31:0]  y_in;
      logic [31:0]  a_ff [SQRT_STEPS+1];

      // one root bit per stage
      function automatic emp_sqrt_type sqrt_step(input emp_sqrt_type s);
         emp_sqrt_type n;
         logic [26:0]  r;
         logic [26:0]  trial;
         logic         ge;
         n       = s;
         r       = {s.rem[24:0], s.rad[49:48]};
         trial   = {s.root, 2'b01};
         ge      = r >= trial;
         n.rem   = ge ? (r - trial) : r;
         n.root  = {s.root[23:0], ge};
         n.rad   = s.rad << 2;
         return n;
      endfunction

      // classify, normalize, make the exponent even
      always_comb begin
         logic [5:0]         lz;
         logic [23:0]        m;
         logic signed [11:0] e;
         lz = lzc48({mant_of(op_a), 24'd0});
         m  = mant_of(op_a) << lz;
         e  = {4'd0, exp_of(op_a)} - 12'sd127 - $signed({6'd0, lz});
         if (e[0]) begin
            sq_in.rad = {m, 1'b0, 25'd0};
            sq_in.ex  = e - 12'sd1;
         end else begin
            sq_in.rad = {1'b0, m, 25'd0};
            sq_in.ex  = e;
         end
         sq_in.rem  = 27'd0;
         sq_in.root = 25'd0;
         sq_in.flags.nan  = is_nan(op_a) || (op_a[31] && !is_zero(op_a));
         sq_in.flags.inf  = is_inf(op_a) && !op_a[31];
         sq_in.flags.zero = is_zero(op_a);
         sq_in.flags.sgn  = op_a[31];
      end

      // round the root and pack
      always_comb begin
         emp_sqrt_type       s;
         logic [23:0]        q;
         logic               inc;
         logic signed [11:0] ef;
         logic [31:0]        packed_val;
         s   = sq_ff[SQRT_STEPS];
         q   = s.root[24:1];
         inc = s.root[0] & ((s.rem != 27'd0) | q[0]);
         ef  = (s.ex >>> 1) + 12'sd126;
         packed_val = {1'b0, ef[7:0], 23'd0} + {7'd0, {1'b0, q} + {24'd0, inc}};
         if (s.flags.nan) begin
            y_in = CANON_NAN;
         end else if (s.flags.inf || s.flags.zero) begin
            y_in = a_ff[SQRT_STEPS];
         end else begin
            y_in = packed_val;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[0] <= sq_in;
            a_ff[0]  <= op_a;
            for (int k = 0; k < SQRT_STEPS; k++) begin
               sq_ff[k+1] <= sqrt_step(sq_ff[k]);
               a_ff[k+1]  <= a_ff[k];
            end
            y_ff <= y_in;
         end
      end

      assign result = y_ff;

   end

endmodule

`default_nettype wire

// ===== rtl/elastic_material_parameters.sv =====
// top level: elastic material parameters from Young's modulus, Poisson's ratio, density
//
// Per request the block takes E, nu and rho as binary32 bit patterns and returns
// lambda = E*nu/((1+nu)(1-2nu)), mu = E/(2(1+nu)), kappa = E/(3(1-2nu)) and
// c = sqrt((lambda+2mu)/rho), each op rounded to nearest even, NaN made canonical.
// Channels: req_* in, rsp_* out, both valid/stall; a request moves on an edge
// with valid high and stall low. Exactly one response per request, in order.
// Levels: five add/multiply, two divider and one square root level.
// Throughput: one request per cycle while the pipeline is not held; every stage
// is a register and the dividers and square root produce one bit per stage.
// When the receiver stalls with a response waiting, the whole pipeline holds
// and req_stall goes high; bubbles still advance while no response is pending.
// Reset clears only the valid bits and holds req_stall high; data registers
// are not reset.
`default_nettype none

module elastic_material_parameters
   import emp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_young_modulus,
   input  wire logic [31:0] req_poisson_ratio,
   input  wire logic [31:0] req_mass_density,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [31:0] rsp_lame_lambda,
   output logic      [31:0] rsp_shear_modulus,
   output logic      [31:0] rsp_bulk_modulus,
   output logic      [31:0] rsp_wave_speed
);

   // times at which each level's results appear
   localparam int T1 = LAT_AM;
   localparam int T2 = T1 + LAT_AM;
   localparam int T3 = T2 + LAT_AM;
   localparam int T4 = T3 + LAT_DIV;
   localparam int T5 = T4 + LAT_AM;
   localparam int T6 = T5 + LAT_AM;
   localparam int T7 = T6 + LAT_DIV;
   localparam int T8 = T7 + LAT_SQRT;

   logic        adv;
   logic        valid_ff [T8];
   logic [31:0] one_plus, two_nu, num, one_minus, den, two_onep, three_onem;
   logic [31:0] lam, mu, kap, two_mu, sum, rad, speed;
   logic [31:0] e_ff     [T3];
   logic [31:0] rho_ff   [T6];
   logic [31:0] onep_ff  [T2-T1];
   logic [31:0] num_ff   [T3-T1];
   logic [31:0] lam_ff   [T5-T4];
   logic [95:0] res_ff   [T8-T4];

   // the pipeline moves unless a response is held by the receiver
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = reset || !adv;
   assign rsp_valid = valid_ff[T8-1];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < T8; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < T8; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // delay lines for operands used at later levels
   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff[0]    <= req_young_modulus;
         rho_ff[0]  <= req_mass_density;
         onep_ff[0] <= one_plus;
         num_ff[0]  <= num;
         lam_ff[0]  <= lam;
         res_ff[0]  <= {lam, mu, kap};
         for (int i = 1; i < T3; i++) begin
            e_ff[i] <= e_ff[i-1];
         end
         for (int i = 1; i < T6; i++) begin
            rho_ff[i] <= rho_ff[i-1];
         end
         for (int i = 1; i < T2 - T1; i++) begin
            onep_ff[i] <= onep_ff[i-1];
         end
         for (int i = 1; i < T3 - T1; i++) begin
            num_ff[i] <= num_ff[i-1];
         end
         for (int i = 1; i < T5 - T4; i++) begin
            lam_ff[i] <= lam_ff[i-1];
         end
         for (int i = 1; i < T8 - T4; i++) begin
            res_ff[i] <= res_ff[i-1];
         end
      end
   end

   // level 1: 1+nu, 2*nu, E*nu
   emp_fpu #(.OP(OP_ADD)) u_one_plus (.clock(clock), .en(adv), .op_a(FP_ONE),
      .op_b(req_poisson_ratio), .result(one_plus));
   emp_fpu #(.OP(OP_MUL)) u_two_nu (.clock(clock), .en(adv), .op_a(FP_TWO),
      .op_b(req_poisson_ratio), .result(two_nu));
   emp_fpu #(.OP(OP_MUL)) u_num (.clock(clock), .en(adv), .op_a(req_young_modulus),
      .op_b(req_poisson_ratio), .result(num));

   // level 2: 1 - 2nu
   emp_fpu #(.OP(OP_ADD)) u_one_minus (.clock(clock), .en(adv), .op_a(FP_ONE),
      .op_b({~two_nu[31], two_nu[30:0]}), .result(one_minus));

   // level 3: denominators
   emp_fpu #(.OP(OP_MUL)) u_den (.clock(clock), .en(adv), .op_a(onep_ff[T2-T1-1]),
      .op_b(one_minus), .result(den));
   emp_fpu #(.OP(OP_MUL)) u_two_onep (.clock(clock), .en(adv), .op_a(FP_TWO),
      .op_b(onep_ff[T2-T1-1]), .result(two_onep));
   emp_fpu #(.OP(OP_MUL)) u_three_onem (.clock(clock), .en(adv), .op_a(FP_THREE),
      .op_b(one_minus), .result(three_onem));

   // level 4: lambda, mu, kappa
   emp_fpu #(.OP(OP_DIV)) u_lam (.clock(clock), .en(adv), .op_a(num_ff[T3-T1-1]),
      .op_b(den), .result(lam));
   emp_fpu #(.OP(OP_DIV)) u_mu (.clock(clock), .en(adv), .op_a(e_ff[T3-1]),
      .op_b(two_onep), .result(mu));
   emp_fpu #(.OP(OP_DIV)) u_kap (.clock(clock), .en(adv), .op_a(e_ff[T3-1]),
      .op_b(three_onem), .result(kap));

   // levels 5 and 6: lambda + 2mu
   emp_fpu #(.OP(OP_MUL)) u_two_mu (.clock(clock), .en(adv), .op_a(FP_TWO),
      .op_b(mu), .result(two_mu));
   emp_fpu #(.OP(OP_ADD)) u_sum (.clock(clock), .en(adv), .op_a(lam_ff[T5-T4-1]),
      .op_b(two_mu), .result(sum));

   // levels 7 and 8: wave speed
   emp_fpu #(.OP(OP_DIV)) u_rad (.clock(clock), .en(adv), .op_a(sum),
      .op_b(rho_ff[T6-1]), .result(rad));
   emp_fpu #(.OP(OP_SQRT)) u_speed (.clock(clock), .en(adv), .op_a(rad),
      .op_b(32'd0), .result(speed));

   // response fields
   assign rsp_lame_lambda   = res_ff[T8-T4-1][95:64];
   assign rsp_shear_modulus = res_ff[T8-T4-1][63:32];
   assign rsp_bulk_modulus  = res_ff[T8-T4-1][31:0];
   assign rsp_wave_speed    = speed;

endmodule

`default_nettype wire
